[sv/ipf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared types, constants and helpers of the integer printf formatter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int MAX_FIELD   = 62;
  localparam int MAX_DIGITS  = 20;
  localparam int VALUE_W     = 64;
  localparam int FIELD_W     = 6;
  localparam int DIGIT_W     = 4;
  localparam int BCD_W       = MAX_DIGITS * DIGIT_W;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int CONV_BITS   = 4;
  localparam int CONV_STEPS  = VALUE_W / CONV_BITS;
  localparam int STEP_W      = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = FIELD_W + 2;

  // Conversion kinds.
  localparam logic [1:0] KIND_SDEC = 2'd0;
  localparam logic [1:0] KIND_UDEC = 2'd1;
  localparam logic [1:0] KIND_LHEX = 2'd2;
  localparam logic [1:0] KIND_UHEX = 2'd3;

  // ASCII codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [1:0]         conv_kind;
    logic               left_align;
    logic               zero_pad;
    logic               plus_sign;
    logic               space_sign;
    logic               alt_prefix;
    logic               keep_prefix;
    logic [FIELD_W-1:0] field_width;
    logic [FIELD_W-1:0] precision;
    logic               precision_dot_only;
  } ipf_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_char;
  } ipf_out_t;

  // One classified item as it waits between front and back.
  typedef struct packed {
    logic [VALUE_W-1:0] magnitude;
    logic               is_hex;
    logic               caps;
    logic [1:0]         head_len;
    logic [7:0]         head0;
    logic [7:0]         head1;
    logic               left_align;
    logic               zero_pad;
    logic               dot_only;
    logic [FIELD_W-1:0] field_width;
    logic [FIELD_W-1:0] precision;
  } ipf_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } ipf_state_t;

  function automatic logic [7:0] glyph(input logic [DIGIT_W-1:0] d, input logic caps);
    logic [7:0] d8;
    d8 = {{(8 - DIGIT_W){1'b0}}, d};
    if (d8 < 8'd10) begin
      return CH_ZERO + d8;
    end else begin
      return (caps ? CH_A_UP : CH_A_LO) + d8 - 8'd10;
    end
  endfunction

  function automatic logic [FIELD_W-1:0] sat_field(input logic [FIELD_W-1:0] f);
    if (f > FIELD_W'(MAX_FIELD)) begin
      return FIELD_W'(MAX_FIELD);
    end else begin
      return f;
    end
  endfunction

endpackage

[sv/ipf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_front
// Accepts words and classifies them: sign, prefix, magnitude, clamped sizes.
// ----------------------------------------------------------------------------
module ipf_front (
  input  logic             in_valid,
  output logic             in_stall,
  input  ipf_pkg::ipf_in_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output ipf_pkg::ipf_job_t q_job
);

  logic neg;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign neg      = in_data.value[ipf_pkg::VALUE_W-1];

  always_comb begin
    q_job             = '0;
    q_job.magnitude   = in_data.value;
    q_job.is_hex      = in_data.conv_kind[1];
    q_job.caps        = (in_data.conv_kind == ipf_pkg::KIND_UHEX);
    q_job.head_len    = 2'd0;
    q_job.head0       = ipf_pkg::CH_NUL;
    q_job.head1       = ipf_pkg::CH_NUL;
    q_job.left_align  = in_data.left_align;
    q_job.zero_pad    = in_data.zero_pad;
    q_job.dot_only    = in_data.precision_dot_only;
    q_job.field_width = ipf_pkg::sat_field(in_data.field_width);
    q_job.precision   = ipf_pkg::sat_field(in_data.precision);
    unique case (in_data.conv_kind)
      ipf_pkg::KIND_SDEC: begin
        // Space wins over plus for nonnegative values.
        priority if (neg) begin
          q_job.magnitude = '0 - in_data.value;
          q_job.head_len  = 2'd1;
          q_job.head0     = ipf_pkg::CH_MINUS;
        end else if (in_data.space_sign) begin
          q_job.head_len = 2'd1;
          q_job.head0    = ipf_pkg::CH_SPACE;
        end else if (in_data.plus_sign) begin
          q_job.head_len = 2'd1;
          q_job.head0    = ipf_pkg::CH_PLUS;
        end
      end
      ipf_pkg::KIND_UDEC: begin
      end
      ipf_pkg::KIND_LHEX, ipf_pkg::KIND_UHEX: begin
        if (in_data.alt_prefix && (in_data.keep_prefix || (in_data.value != '0))) begin
          q_job.head_len = 2'd2;
          q_job.head0    = ipf_pkg::CH_ZERO;
          q_job.head1    = (in_data.conv_kind == ipf_pkg::KIND_UHEX) ?
                           ipf_pkg::CH_X_UP : ipf_pkg::CH_X_LO;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/ipf_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ipf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ipf_pkg::ipf_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output ipf_pkg::ipf_job_t pop_job
);

  ipf_pkg::ipf_job_t                entry_r [ipf_pkg::QUEUE_DEPTH];
  logic [ipf_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ipf_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ipf_pkg::QCNT_W-1:0]      count_r,  count_nxt;
  logic                             do_push, do_pop;

  assign full      = (count_r == ipf_pkg::QCNT_W'(ipf_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_job   = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ipf_pkg::QPTR_W'(ipf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ipf_pkg::QPTR_W'(ipf_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/ipf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_back
// Converts the magnitude to digits, sizes the padding and emits characters.
// ----------------------------------------------------------------------------
module ipf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ipf_pkg::ipf_job_t q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output ipf_pkg::ipf_out_t out_data
);

  ipf_pkg::ipf_state_t             state_r, state_nxt;
  ipf_pkg::ipf_job_t               job_r, job_nxt;
  logic [ipf_pkg::VALUE_W-1:0]     bin_r, bin_nxt;
  logic [ipf_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [ipf_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [ipf_pkg::FIELD_W-1:0]     padl_r, padl_nxt;
  logic [1:0]                      head_r, head_nxt;
  logic [ipf_pkg::FIELD_W-1:0]     zero_r, zero_nxt;
  logic [ipf_pkg::CNT_W-1:0]       dig_r, dig_nxt;
  logic [ipf_pkg::FIELD_W-1:0]     padr_r, padr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ipf_pkg::ipf_out_t               out_data_r, out_data_nxt;

  logic                            slot_free;
  logic [ipf_pkg::BCD_W-1:0]       bcd_step;
  logic [ipf_pkg::VALUE_W-1:0]     bin_step;
  logic [ipf_pkg::CNT_W-1:0]       dcnt;
  logic [ipf_pkg::SUM_W-1:0]       len_w, lz_w, tot_w, gap_w, wid_w, prec_w, sp_w;
  logic [ipf_pkg::SUM_W-1:0]       remain;
  logic [ipf_pkg::CNT_W-1:0]       dig_idx;
  logic [ipf_pkg::DIGIT_W-1:0]     dig_val;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign q_pop     = (state_r == ipf_pkg::ST_IDLE) && q_valid;

  // Shift-and-add-3 binary to BCD, a few bits per cycle.
  always_comb begin
    logic [ipf_pkg::DIGIT_W-1:0] d;
    bcd_step = bcd_r;
    bin_step = bin_r;
    for (int s = 0; s < ipf_pkg::CONV_BITS; s++) begin
      for (int k = 0; k < ipf_pkg::MAX_DIGITS; k++) begin
        d = bcd_step[k*ipf_pkg::DIGIT_W +: ipf_pkg::DIGIT_W];
        if (d >= ipf_pkg::DIGIT_W'(5)) begin
          bcd_step[k*ipf_pkg::DIGIT_W +: ipf_pkg::DIGIT_W] = d + ipf_pkg::DIGIT_W'(3);
        end
      end
      bcd_step = {bcd_step[ipf_pkg::BCD_W-2:0], bin_step[ipf_pkg::VALUE_W-1]};
      bin_step = {bin_step[ipf_pkg::VALUE_W-2:0], 1'b0};
    end
  end

  // Digit count of the store, at least one unless dot_only.
  always_comb begin
    dcnt = '0;
    for (int k = 0; k < ipf_pkg::MAX_DIGITS; k++) begin
      if (bcd_r[k*ipf_pkg::DIGIT_W +: ipf_pkg::DIGIT_W] != '0) begin
        dcnt = ipf_pkg::CNT_W'(k + 1);
      end
    end
    if ((dcnt == '0) && !job_r.dot_only) begin
      dcnt = ipf_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    wid_w  = ipf_pkg::SUM_W'(job_r.field_width);
    prec_w = ipf_pkg::SUM_W'(job_r.precision);
    len_w  = ipf_pkg::SUM_W'(dcnt);
    lz_w   = '0;
    sp_w   = '0;
    if (prec_w > len_w) begin
      lz_w  = prec_w - len_w;
      len_w = prec_w;
    end
    tot_w = len_w + ipf_pkg::SUM_W'(job_r.head_len);
    gap_w = wid_w - tot_w;
    if (wid_w >= tot_w) begin
      // Zero padding adds to the precision zeros, whatever the alignment.
      if (job_r.zero_pad) begin
        lz_w = lz_w + gap_w;
      end else begin
        sp_w = gap_w;
      end
    end
  end

  assign remain = ipf_pkg::SUM_W'(padl_r) + ipf_pkg::SUM_W'(head_r) +
                  ipf_pkg::SUM_W'(zero_r) + ipf_pkg::SUM_W'(dig_r) +
                  ipf_pkg::SUM_W'(padr_r);
  assign dig_idx = dig_r - 1'b1;
  assign dig_val = bcd_r[dig_idx*ipf_pkg::DIGIT_W +: ipf_pkg::DIGIT_W];

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    padl_nxt      = padl_r;
    head_nxt      = head_r;
    zero_nxt      = zero_r;
    dig_nxt       = dig_r;
    padr_nxt      = padr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ipf_pkg::ST_IDLE: begin
        if (q_valid) begin
          job_nxt = q_job;
          if (q_job.is_hex) begin
            bcd_nxt   = ipf_pkg::BCD_W'(q_job.magnitude);
            state_nxt = ipf_pkg::ST_SIZE;
          end else begin
            bcd_nxt   = '0;
            bin_nxt   = q_job.magnitude;
            step_nxt  = '0;
            state_nxt = ipf_pkg::ST_CONV;
          end
        end
      end
      ipf_pkg::ST_CONV: begin
        bcd_nxt  = bcd_step;
        bin_nxt  = bin_step;
        step_nxt = step_r + 1'b1;
        if (step_r == ipf_pkg::STEP_W'(ipf_pkg::CONV_STEPS - 1)) begin
          state_nxt = ipf_pkg::ST_SIZE;
        end
      end
      ipf_pkg::ST_SIZE: begin
        padl_nxt  = job_r.left_align ? '0 : sp_w[ipf_pkg::FIELD_W-1:0];
        padr_nxt  = job_r.left_align ? sp_w[ipf_pkg::FIELD_W-1:0] : '0;
        head_nxt  = job_r.head_len;
        zero_nxt  = lz_w[ipf_pkg::FIELD_W-1:0];
        dig_nxt   = dcnt;
        state_nxt = ipf_pkg::ST_EMIT;
      end
      ipf_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.char_valid = 1'b1;
          out_data_nxt.last_char  = (remain == ipf_pkg::SUM_W'(1));
          priority if (padl_r != '0) begin
            out_data_nxt.out_char = ipf_pkg::CH_SPACE;
            padl_nxt = padl_r - 1'b1;
          end else if (head_r != '0) begin
            out_data_nxt.out_char = (head_r == job_r.head_len) ? job_r.head0 : job_r.head1;
            head_nxt = head_r - 1'b1;
          end else if (zero_r != '0) begin
            out_data_nxt.out_char = ipf_pkg::CH_ZERO;
            zero_nxt = zero_r - 1'b1;
          end else if (dig_r != '0) begin
            out_data_nxt.out_char = ipf_pkg::glyph(dig_val, job_r.caps);
            dig_nxt = dig_r - 1'b1;
          end else if (padr_r != '0) begin
            out_data_nxt.out_char = ipf_pkg::CH_SPACE;
            padr_nxt = padr_r - 1'b1;
          end else begin
            // Nothing to print: one empty word closes the item.
            out_data_nxt.out_char   = ipf_pkg::CH_NUL;
            out_data_nxt.char_valid = 1'b0;
            out_data_nxt.last_char  = 1'b1;
          end
          if (remain <= ipf_pkg::SUM_W'(1)) begin
            state_nxt = ipf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ipf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    step_r     <= step_nxt;
    padl_r     <= padl_nxt;
    head_r     <= head_nxt;
    zero_r     <= zero_nxt;
    dig_r      <= dig_nxt;
    padr_r     <= padr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[sv/integer_printf_formatter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_printf_formatter
// Formats one 64-bit integer per input word as printf text, one character
// per output word.
// ----------------------------------------------------------------------------
// Each input word is classified on acceptance and parked in a two-entry
// queue, so new words are taken while an earlier one is still printing.
// The back end handles one item at a time: it loads the item, converts
// binary to BCD (4 bits per cycle, decimal kinds only; hex loads its
// nibbles directly), sizes the padding, then sends one character per
// cycle, at most 64, while the output does not stall. Empty output is
// sent as a single word with char_valid low.
module integer_printf_formatter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ipf_pkg::ipf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ipf_pkg::ipf_out_t out_data
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  ipf_pkg::ipf_job_t push_job;
  ipf_pkg::ipf_job_t pop_job;

  ipf_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  ipf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_job   (pop_job)
  );

  ipf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
